// ----- src/ies_pkg.sv -----
// ----------------------------------------------------------------------------
// ies_pkg: shared types and constants of the input event state tracker
// Holds the command codes, register indexes and the structs that pass
// between the tracker's modules.
// ----------------------------------------------------------------------------
package ies_pkg;

    localparam int KEY_COUNT_DEF = 256;

    localparam int CMD_W     = 2;
    localparam int SEQ_W     = 64;
    localparam int KEY_W     = 16;
    localparam int TRANS_W   = 2;
    localparam int POS_W     = 32;
    localparam int WHEEL_W   = 64;
    localparam int FLAGS_W   = 10;
    localparam int BUTTON_N  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [KEY_W-1:0] KEY_STATE_DOWN    = 16'h8000;
    localparam logic [KEY_W-1:0] KEY_STATE_PRESSED = 16'h0001;

    localparam int S_TDATA_W = 256;
    localparam int M_TDATA_W = 152;

    typedef enum logic [CMD_W-1:0] {
        CMD_KEY        = 2'd0,
        CMD_MOUSE      = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_QUERY      = 2'd3
    } t_cmd;

    typedef enum logic [TRANS_W-1:0] {
        TRANS_UP   = 2'd0,
        TRANS_DOWN = 2'd1,
        TRANS_BAD2 = 2'd2,
        TRANS_BAD3 = 2'd3
    } t_trans;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_ENABLE = 3'd0,
        CFG_CLIP_LEFT   = 3'd1,
        CFG_CLIP_TOP    = 3'd2,
        CFG_CLIP_RIGHT  = 3'd3,
        CFG_CLIP_BOTTOM = 3'd4
    } t_cfg_reg;

    // Fields are listed from the highest bits down, so the first field of
    // the beat lands in the lowest bits.
    typedef struct packed {
        logic signed [POS_W-1:0]   new_y;
        logic signed [POS_W-1:0]   new_x;
        logic [FLAGS_W-1:0]        button_flags;
        logic signed [POS_W-1:0]   wheel_delta;
        logic signed [POS_W-1:0]   delta_y;
        logic signed [POS_W-1:0]   delta_x;
        t_trans                    key_transition;
        logic [KEY_W-1:0]          key_code;
        logic [SEQ_W-1:0]          sequence_req;
        t_cmd                      cmd;
    } t_item;

    typedef struct packed {
        logic [BUTTON_N-1:0]       buttons_out;
        logic signed [WHEEL_W-1:0] wheel_total;
        logic signed [POS_W-1:0]   cursor_y_out;
        logic signed [POS_W-1:0]   cursor_x_out;
        logic [KEY_W-1:0]          key_state;
        logic                      accepted;
    } t_result;

    typedef struct packed {
        logic wr;
        logic down;
        logic query;
    } t_key_ctl;

    typedef struct packed {
        logic key_dn;
        logic key_pe;
    } t_key_stat;

    typedef struct packed {
        logic mouse;
        logic set_pos;
    } t_ptr_ctl;

    typedef struct packed {
        logic                    enable;
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] upper;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] lower;
    } t_clip;

endpackage

// ----- src/ies_key_map.sv -----
// ----------------------------------------------------------------------------
// ies_key_map: key down and press-edge maps
// One down bit and one press-edge bit per key, read and updated at one key
// index per beat.
// ----------------------------------------------------------------------------
module ies_key_map #(
    parameter int KEY_COUNT = ies_pkg::KEY_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  ies_pkg::t_key_ctl            i_ctl,
    input  logic [$clog2(KEY_COUNT)-1:0] i_idx,
    output ies_pkg::t_key_stat           o_stat
);
    import ies_pkg::*;

    logic [KEY_COUNT-1:0] r_down;
    logic [KEY_COUNT-1:0] r_pressed;

    assign o_stat.key_dn = r_down[i_idx];
    assign o_stat.key_pe = r_pressed[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down    <= '0;
            r_pressed <= '0;
        end else if (i_en) begin
            if (i_ctl.wr) begin
                r_down[i_idx] <= i_ctl.down;
                if (i_ctl.down && !r_down[i_idx]) begin
                    r_pressed[i_idx] <= 1'b1;
                end
            end else if (i_ctl.query) begin
                r_pressed[i_idx] <= 1'b0;
            end
        end
    end

endmodule

// ----- src/ies_pointer.sv -----
// ----------------------------------------------------------------------------
// ies_pointer: cursor, wheel total and mouse buttons
// Saturating cursor and wheel updates, button set and clear, and the clamp
// of the cursor to the clip rectangle. Outputs the values after the beat.
// ----------------------------------------------------------------------------
module ies_pointer (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  ies_pkg::t_ptr_ctl                        i_ctl,
    input  ies_pkg::t_clip                           i_clip,
    input  logic signed [ies_pkg::POS_W-1:0]         i_delta_x,
    input  logic signed [ies_pkg::POS_W-1:0]         i_delta_y,
    input  logic signed [ies_pkg::POS_W-1:0]         i_wheel_delta,
    input  logic [ies_pkg::FLAGS_W-1:0]              i_button_flags,
    input  logic signed [ies_pkg::POS_W-1:0]         i_new_x,
    input  logic signed [ies_pkg::POS_W-1:0]         i_new_y,
    output logic signed [ies_pkg::POS_W-1:0]         o_cursor_x,
    output logic signed [ies_pkg::POS_W-1:0]         o_cursor_y,
    output logic signed [ies_pkg::WHEEL_W-1:0]       o_wheel,
    output logic [ies_pkg::BUTTON_N-1:0]             o_buttons
);
    import ies_pkg::*;

    logic signed [POS_W-1:0]   r_cursor_x;
    logic signed [POS_W-1:0]   r_cursor_y;
    logic signed [WHEEL_W-1:0] r_wheel;
    logic [BUTTON_N-1:0]       r_buttons;

    logic signed [POS_W-1:0]   n_cursor_x;
    logic signed [POS_W-1:0]   n_cursor_y;
    logic signed [WHEEL_W-1:0] n_wheel;
    logic [BUTTON_N-1:0]       n_buttons;

    logic signed [POS_W:0]     sum_x;
    logic signed [POS_W:0]     sum_y;
    logic signed [WHEEL_W:0]   sum_w;
    logic signed [POS_W-1:0]   sat_x;
    logic signed [POS_W-1:0]   sat_y;
    logic signed [WHEEL_W-1:0] sat_w;
    logic signed [POS_W-1:0]   pre_x;
    logic signed [POS_W-1:0]   pre_y;
    logic signed [POS_W-1:0]   max_x;
    logic signed [POS_W-1:0]   max_y;
    logic                      clip_on;
    logic [BUTTON_N-1:0]       btn_mouse;

    localparam logic signed [POS_W-1:0]   PosMax   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]   PosMin   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [WHEEL_W-1:0] WheelMax = {1'b0, {(WHEEL_W-1){1'b1}}};
    localparam logic signed [WHEEL_W-1:0] WheelMin = {1'b1, {(WHEEL_W-1){1'b0}}};

    always_comb begin
        sum_x = {r_cursor_x[POS_W-1], r_cursor_x} + {i_delta_x[POS_W-1], i_delta_x};
        sum_y = {r_cursor_y[POS_W-1], r_cursor_y} + {i_delta_y[POS_W-1], i_delta_y};
        sum_w = {r_wheel[WHEEL_W-1], r_wheel}
              + {{(WHEEL_W-POS_W+1){i_wheel_delta[POS_W-1]}}, i_wheel_delta};

        if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            sat_x = sum_x[POS_W] ? PosMin : PosMax;
        end else begin
            sat_x = sum_x[POS_W-1:0];
        end
        if (sum_y[POS_W] != sum_y[POS_W-1]) begin
            sat_y = sum_y[POS_W] ? PosMin : PosMax;
        end else begin
            sat_y = sum_y[POS_W-1:0];
        end
        if (sum_w[WHEEL_W] != sum_w[WHEEL_W-1]) begin
            sat_w = sum_w[WHEEL_W] ? WheelMin : WheelMax;
        end else begin
            sat_w = sum_w[WHEEL_W-1:0];
        end

        pre_x = i_ctl.mouse ? sat_x : i_new_x;
        pre_y = i_ctl.mouse ? sat_y : i_new_y;

        clip_on = i_clip.enable && (i_clip.right > i_clip.left)
                  && (i_clip.lower > i_clip.upper);
        max_x   = i_clip.right - POS_W'(1);
        max_y   = i_clip.lower - POS_W'(1);

        n_cursor_x = pre_x;
        n_cursor_y = pre_y;
        if (clip_on) begin
            if (pre_x < i_clip.left) begin
                n_cursor_x = i_clip.left;
            end else if (pre_x > max_x) begin
                n_cursor_x = max_x;
            end
            if (pre_y < i_clip.upper) begin
                n_cursor_y = i_clip.upper;
            end else if (pre_y > max_y) begin
                n_cursor_y = max_y;
            end
        end

        for (int i = 0; i < BUTTON_N; i++) begin
            if (i_button_flags[2*i+1]) begin
                btn_mouse[i] = 1'b0;
            end else if (i_button_flags[2*i]) begin
                btn_mouse[i] = 1'b1;
            end else begin
                btn_mouse[i] = r_buttons[i];
            end
        end

        if (i_en && (i_ctl.mouse || i_ctl.set_pos)) begin
            n_wheel   = i_ctl.mouse ? sat_w : r_wheel;
            n_buttons = i_ctl.mouse ? btn_mouse : r_buttons;
        end else begin
            n_cursor_x = r_cursor_x;
            n_cursor_y = r_cursor_y;
            n_wheel    = r_wheel;
            n_buttons  = r_buttons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_wheel    <= '0;
            r_buttons  <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_wheel    <= n_wheel;
            r_buttons  <= n_buttons;
        end
    end

    assign o_cursor_x = n_cursor_x;
    assign o_cursor_y = n_cursor_y;
    assign o_wheel    = n_wheel;
    assign o_buttons  = n_buttons;

endmodule

// ----- src/input_event_state_tracker_core.sv -----
// ----------------------------------------------------------------------------
// input_event_state_tracker_core: keyboard and mouse state tracker
// Applies sequenced key, mouse and set-cursor events, answers key queries,
// and returns one result beat per input beat.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         256    one event or query per beat
//   m_axis    out        152    one result per accepted input beat
//   cfg       in         32     clip enable and clip rectangle writes
//
// A beat is taken into an input register and processed from there, which
// loads the result register, from which its result is offered on m_axis.
// One beat per cycle is sustained while m_axis does not stall; the state
// update of the processing stage is the single step that sets this figure.
// Reset clears all key, pointer and sequence state and the clip registers.
// A stall on m_axis holds the result register and backs up to s_axis.
// ----------------------------------------------------------------------------
module input_event_state_tracker_core #(
    parameter int KEY_COUNT = ies_pkg::KEY_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cmd, sequence_req, key_code, key_transition, delta_x, delta_y,
    // wheel_delta, button_flags, new_x, new_y, zero pad
    input  logic [ies_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // accepted, key_state, cursor_x_out, cursor_y_out, wheel_total,
    // buttons_out, zero pad
    output logic [ies_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [ies_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [ies_pkg::CFG_W-1:0]            i_cfg_wr_data
);
    import ies_pkg::*;

    localparam int KeyIdxW = $clog2(KEY_COUNT);
    localparam logic [KEY_W:0] KeyLimit = (KEY_W+1)'(KEY_COUNT);
    localparam int ItemW   = $bits(t_item);
    localparam int ResultW = $bits(t_result);

    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    t_result             r_out;
    logic [SEQ_W-1:0]    r_last_seq;
    t_clip               r_clip;

    logic                advance;
    logic                key_ok;
    logic                seq_ok;
    logic                key_apply;
    logic                mouse_apply;
    logic                set_apply;
    logic                query_ok;
    t_key_ctl            key_ctl;
    t_key_stat           key_stat;
    t_ptr_ctl            ptr_ctl;
    t_result             n_out;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        key_ok      = {1'b0, r_in.key_code} < KeyLimit;
        seq_ok      = (r_in.sequence_req != '0) && (r_in.sequence_req > r_last_seq);
        key_apply   = (r_in.cmd == CMD_KEY) && seq_ok && key_ok
                      && ((r_in.key_transition == TRANS_UP)
                          || (r_in.key_transition == TRANS_DOWN));
        mouse_apply = (r_in.cmd == CMD_MOUSE) && seq_ok;
        set_apply   = (r_in.cmd == CMD_SET_CURSOR) && seq_ok;
        query_ok    = (r_in.cmd == CMD_QUERY) && key_ok;

        key_ctl.wr    = key_apply;
        key_ctl.down  = (r_in.key_transition == TRANS_DOWN);
        key_ctl.query = query_ok;

        ptr_ctl.mouse   = mouse_apply;
        ptr_ctl.set_pos = set_apply;

        n_out.accepted  = key_apply || mouse_apply || set_apply || query_ok;
        n_out.key_state = '0;
        if (query_ok) begin
            n_out.key_state = (key_stat.key_dn ? KEY_STATE_DOWN : '0)
                            | (key_stat.key_pe ? KEY_STATE_PRESSED : '0);
        end
    end

    ies_key_map #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (key_ctl),
        .i_idx   (r_in.key_code[KeyIdxW-1:0]),
        .o_stat  (key_stat)
    );

    ies_pointer u_pointer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_ctl          (ptr_ctl),
        .i_clip         (r_clip),
        .i_delta_x      (r_in.delta_x),
        .i_delta_y      (r_in.delta_y),
        .i_wheel_delta  (r_in.wheel_delta),
        .i_button_flags (r_in.button_flags),
        .i_new_x        (r_in.new_x),
        .i_new_y        (r_in.new_y),
        .o_cursor_x     (n_out.cursor_x_out),
        .o_cursor_y     (n_out.cursor_y_out),
        .o_wheel        (n_out.wheel_total),
        .o_buttons      (n_out.buttons_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_seq  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && (key_apply || mouse_apply || set_apply)) begin
                r_last_seq <= r_in.sequence_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_item'(s_axis_tdata[ItemW-1:0]);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_CLIP_ENABLE: r_clip.enable <= i_cfg_wr_data[0];
                CFG_CLIP_LEFT:   r_clip.left   <= i_cfg_wr_data;
                CFG_CLIP_TOP:    r_clip.upper  <= i_cfg_wr_data;
                CFG_CLIP_RIGHT:  r_clip.right  <= i_cfg_wr_data;
                CFG_CLIP_BOTTOM: r_clip.lower  <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W-ResultW)'(0), r_out};

endmodule
